// File: hdl/tcv_pkg.sv
// types, constants and codes shared by the token character set validator
package tcv_pkg;

   localparam int MAX_TOKEN_LEN = 255;
   localparam int COUNT_W = 9;
   localparam logic [COUNT_W-1:0] COUNT_SAT = COUNT_W'(MAX_TOKEN_LEN + 1);

   localparam logic [7:0] PRINT_LO = 8'h20;
   localparam logic [7:0] PRINT_HI = 8'h7E;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_DASH = 8'h2D;
   localparam logic [7:0] CHAR_DOT = 8'h2E;
   localparam logic [7:0] CHAR_SLASH = 8'h2F;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

   typedef enum logic [1:0] {
      PROFILE_LOWER = 2'd0,
      PROFILE_HEX = 2'd1,
      PROFILE_PRINT = 2'd2,
      PROFILE_UNDEF = 2'd3
   } profile_type;

   typedef enum logic [1:0] {
      CSR_PROFILE = 2'd0,
      CSR_LEN_LO = 2'd1,
      CSR_LEN_HI = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      VERDICT_OK = 3'd0,
      VERDICT_LENGTH = 3'd1,
      VERDICT_FIRST = 3'd2,
      VERDICT_LAST = 3'd3,
      VERDICT_CHARSET = 3'd4,
      VERDICT_CONSEC = 3'd5
   } verdict_type;

   typedef struct packed {
      logic [7:0] character;
      logic is_last;
   } req_type;

   typedef struct packed {
      logic [2:0] verdict;
      logic [COUNT_W-1:0] token_length;
   } rsp_type;

   typedef struct packed {
      logic in_set;
      logic sep;
      logic edge_bad;
   } char_class_type;

endpackage

// File: hdl/tcv_classify.sv
// character classification against the selected profile
module tcv_classify (
   input logic [1:0] profile,
   input logic [7:0] character,
   output tcv_pkg::char_class_type cls
);

   logic lower;
   logic digit;
   logic hexlet;
   logic sep_lower;

   assign lower = character inside {[8'h61:8'h7A]};
   assign digit = character inside {[8'h30:8'h39]};
   assign hexlet = character inside {[8'h61:8'h66]};
   assign sep_lower = character inside {tcv_pkg::CHAR_DOT, tcv_pkg::CHAR_DASH,
                                        tcv_pkg::CHAR_UNDERSCORE, tcv_pkg::CHAR_SLASH};

   always_comb begin
      cls = '0;
      case (profile)
         tcv_pkg::PROFILE_LOWER: begin
            cls.sep = sep_lower;
            cls.in_set = lower | digit | sep_lower;
            cls.edge_bad = ~lower & ~digit;
         end
         tcv_pkg::PROFILE_HEX: begin
            cls.sep = (character == tcv_pkg::CHAR_DASH);
            cls.in_set = digit | hexlet | (character == tcv_pkg::CHAR_DASH);
            cls.edge_bad = (character == tcv_pkg::CHAR_DASH);
         end
         tcv_pkg::PROFILE_PRINT: begin
            cls.sep = 1'b0;
            cls.in_set = character inside {[tcv_pkg::PRINT_LO:tcv_pkg::PRINT_HI]};
            cls.edge_bad = (character == tcv_pkg::CHAR_SPACE);
         end
         default: begin
            cls = '0;
         end
      endcase
   end

endmodule

// File: hdl/tcv_checker.sv
// per-token state, verdict selection and result register
module tcv_checker (
   input logic clock,
   input logic reset,
   input logic advance,
   input logic [1:0] profile,
   input logic [7:0] len_lo,
   input logic [7:0] len_hi,
   input tcv_pkg::req_type item,
   input tcv_pkg::char_class_type cls,
   input logic rsp_ready,
   output logic rsp_valid,
   output tcv_pkg::rsp_type rsp_data
);

   logic [tcv_pkg::COUNT_W-1:0] count_ff, count_in, count_next;
   logic prev_sep_ff, prev_sep_in;
   logic first_bad_ff, first_bad_in, first_bad_next;
   tcv_pkg::verdict_type body_err_ff, body_err_in, body_err_next;
   logic rsp_valid_ff, rsp_valid_in;
   tcv_pkg::rsp_type rsp_ff, rsp_in;
   tcv_pkg::verdict_type verdict;
   logic take_result;

   assign take_result = advance & item.is_last;

   always_comb begin
      count_next = (count_ff < tcv_pkg::COUNT_SAT) ? count_ff + 1'b1 : count_ff;
      first_bad_next = (count_ff == '0) ? cls.edge_bad : first_bad_ff;
      body_err_next = body_err_ff;
      if (body_err_ff == tcv_pkg::VERDICT_OK) begin
         if (!cls.in_set) begin
            body_err_next = tcv_pkg::VERDICT_CHARSET;
         end else if (cls.sep && prev_sep_ff) begin
            body_err_next = tcv_pkg::VERDICT_CONSEC;
         end
      end

      if ((count_next < {1'b0, len_lo}) || (count_next > {1'b0, len_hi})) begin
         verdict = tcv_pkg::VERDICT_LENGTH;
      end else if (profile == tcv_pkg::PROFILE_UNDEF) begin
         verdict = tcv_pkg::VERDICT_CHARSET;
      end else if (first_bad_next) begin
         verdict = tcv_pkg::VERDICT_FIRST;
      end else if (cls.edge_bad) begin
         verdict = tcv_pkg::VERDICT_LAST;
      end else begin
         verdict = body_err_next;
      end

      count_in = count_ff;
      prev_sep_in = prev_sep_ff;
      first_bad_in = first_bad_ff;
      body_err_in = body_err_ff;
      if (advance) begin
         if (item.is_last) begin
            count_in = '0;
            prev_sep_in = 1'b0;
            first_bad_in = 1'b0;
            body_err_in = tcv_pkg::VERDICT_OK;
         end else begin
            count_in = count_next;
            prev_sep_in = cls.sep;
            first_bad_in = first_bad_next;
            body_err_in = body_err_next;
         end
      end

      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      if (take_result) begin
         rsp_in.verdict = verdict;
         rsp_in.token_length = count_next;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         prev_sep_ff <= 1'b0;
         first_bad_ff <= 1'b0;
         body_err_ff <= tcv_pkg::VERDICT_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         prev_sep_ff <= prev_sep_in;
         first_bad_ff <= first_bad_in;
         body_err_ff <= body_err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

// File: hdl/token_charset_validator_top.sv
// top level of the token character set validator: csr, input register and checker
// Checks a token that arrives one character per transfer on req_, the final
// character marked by is_last; exactly one result transfer on rsp_ follows
// each marked character, carrying the first failing check and the saturating
// length. Unless stalled, one character is taken per cycle: a character is held
// in the input register, then the classifier and checker update the token state
// and, on the last character, load the result register. The input side stalls only
// while a last character waits for a result register that is still occupied.
// Configuration writes on csr_ take effect at once and belong between tokens.
module token_charset_validator_top (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input tcv_pkg::req_type req_data,
   output logic rsp_valid,
   input logic rsp_ready,
   output tcv_pkg::rsp_type rsp_data,
   input logic csr_we,
   input logic [1:0] csr_index,
   input logic [7:0] csr_wdata
);

   logic [1:0] profile_ff;
   logic [7:0] len_lo_ff;
   logic [7:0] len_hi_ff;
   logic in_valid_ff, in_valid_in;
   tcv_pkg::req_type in_ff, in_in;
   logic advance;
   tcv_pkg::char_class_type cls;

   always_ff @(posedge clock) begin
      if (reset) begin
         profile_ff <= tcv_pkg::PROFILE_LOWER;
         len_lo_ff <= 8'd1;
         len_hi_ff <= 8'd255;
      end else if (csr_we) begin
         case (csr_index)
            tcv_pkg::CSR_PROFILE: profile_ff <= csr_wdata[1:0];
            tcv_pkg::CSR_LEN_LO: len_lo_ff <= csr_wdata;
            tcv_pkg::CSR_LEN_HI: len_hi_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // a last character needs the result register free
   assign advance = in_valid_ff & (~in_ff.is_last | ~rsp_valid | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;

   always_comb begin
      in_valid_in = in_valid_ff & ~advance;
      in_in = in_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_in = req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff <= in_in;
   end

   tcv_classify u_classify (
      .profile(profile_ff),
      .character(in_ff.character),
      .cls(cls)
   );

   tcv_checker u_checker (
      .clock(clock),
      .reset(reset),
      .advance(advance),
      .profile(profile_ff),
      .len_lo(len_lo_ff),
      .len_hi(len_hi_ff),
      .item(in_ff),
      .cls(cls),
      .rsp_ready(rsp_ready),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for the token character set validator top level
module testbench;

   localparam int STALL_LIMIT = 3000;
   localparam int HOLD_CYCLES = 300;

   typedef enum int {
      TOKEN_CLEAN,
      TOKEN_BAD_FIRST,
      TOKEN_BAD_LAST,
      TOKEN_BAD_CHAR,
      TOKEN_DOUBLE_SEP,
      TOKEN_NOISE
   } token_shape_type;

   typedef enum int {
      PICK_EDGE_OK,
      PICK_BODY_OK,
      PICK_PLAIN,
      PICK_SEP,
      PICK_EDGE_BAD,
      PICK_OUTSIDE
   } char_pick_type;

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   tcv_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   tcv_pkg::rsp_type rsp_data;
   logic csr_we = 1'b0;
   tcv_pkg::csr_index_type csr_index = tcv_pkg::CSR_PROFILE;
   logic [7:0] csr_wdata = 8'd0;

   token_charset_validator_top u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   tcv_pkg::req_type pending_chars[$];
   tcv_pkg::rsp_type expected_verdicts[$];
   int mismatches = 0;
   logic req_accepted = 1'b0;
   bit quiet_tail = 1'b0;
   int hold_requests = 0;
   int hold_started = 0;
   int hold_left = 0;
   int ready_gap = 0;
   int send_gap = 0;
   int quiet_cycles = 0;

   // configuration as the block holds it
   tcv_pkg::profile_type cfg_profile = tcv_pkg::PROFILE_LOWER;
   logic [7:0] cfg_min = 8'd1;
   logic [7:0] cfg_max = 8'd255;

   // state of the token being checked
   logic [tcv_pkg::COUNT_W-1:0] tok_count = '0;
   logic tok_prev_sep = 1'b0;
   logic tok_first_bad = 1'b0;
   tcv_pkg::verdict_type tok_body_err = tcv_pkg::VERDICT_OK;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t ns: %s", $time, msg);
      mismatches++;
   endtask

   function automatic tcv_pkg::char_class_type classify(tcv_pkg::profile_type p,
                                                        logic [7:0] c);
      tcv_pkg::char_class_type cls;
      logic lower, digit, hexa, sepc;
      lower = c >= "a" && c <= "z";
      digit = c >= "0" && c <= "9";
      hexa = digit || (c >= "a" && c <= "f");
      sepc = c == tcv_pkg::CHAR_DOT || c == tcv_pkg::CHAR_DASH
         || c == tcv_pkg::CHAR_UNDERSCORE || c == tcv_pkg::CHAR_SLASH;
      cls = '0;
      case (p)
         tcv_pkg::PROFILE_LOWER: begin
            cls.sep = sepc;
            cls.in_set = lower || digit || sepc;
            cls.edge_bad = !(lower || digit);
         end
         tcv_pkg::PROFILE_HEX: begin
            cls.sep = c == tcv_pkg::CHAR_DASH;
            cls.in_set = hexa || c == tcv_pkg::CHAR_DASH;
            cls.edge_bad = c == tcv_pkg::CHAR_DASH;
         end
         tcv_pkg::PROFILE_PRINT: begin
            cls.in_set = c >= tcv_pkg::PRINT_LO && c <= tcv_pkg::PRINT_HI;
            cls.edge_bad = c == tcv_pkg::CHAR_SPACE;
         end
         default: ;
      endcase
      return cls;
   endfunction

   task automatic judge_character(input tcv_pkg::req_type item);
      tcv_pkg::char_class_type cls;
      tcv_pkg::verdict_type v;
      tcv_pkg::rsp_type res;
      cls = classify(cfg_profile, item.character);
      if (tok_count == '0) tok_first_bad = cls.edge_bad;
      if (tok_body_err == tcv_pkg::VERDICT_OK) begin
         if (!cls.in_set) tok_body_err = tcv_pkg::VERDICT_CHARSET;
         else if (cls.sep && tok_prev_sep) tok_body_err = tcv_pkg::VERDICT_CONSEC;
      end
      tok_prev_sep = cls.sep;
      if (tok_count < tcv_pkg::COUNT_SAT) tok_count = tok_count + 1'b1;
      if (item.is_last) begin
         if (tok_count < {1'b0, cfg_min} || tok_count > {1'b0, cfg_max})
            v = tcv_pkg::VERDICT_LENGTH;
         else if (cfg_profile == tcv_pkg::PROFILE_UNDEF) v = tcv_pkg::VERDICT_CHARSET;
         else if (tok_first_bad) v = tcv_pkg::VERDICT_FIRST;
         else if (cls.edge_bad) v = tcv_pkg::VERDICT_LAST;
         else if (tok_body_err != tcv_pkg::VERDICT_OK) v = tok_body_err;
         else v = tcv_pkg::VERDICT_OK;
         res.verdict = v;
         res.token_length = tok_count;
         expected_verdicts = {expected_verdicts, res};
         tok_count = '0;
         tok_prev_sep = 1'b0;
         tok_first_bad = 1'b0;
         tok_body_err = tcv_pkg::VERDICT_OK;
      end
   endtask

   // input side
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_accepted)) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            send_gap <= $urandom_range(0, 7);
            req_valid <= 1'b0;
         end else if (pending_chars.size() != 0) begin
            req_data <= pending_chars.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result side
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (hold_started != hold_requests) begin
         hold_started <= hold_started + 1;
         hold_left <= HOLD_CYCLES - 1;
         rsp_ready <= 1'b0;
      end else if (ready_gap > 0) begin
         ready_gap <= ready_gap - 1;
         rsp_ready <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         ready_gap <= $urandom_range(0, 7);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      tcv_pkg::rsp_type want;
      req_accepted <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (req_valid && req_ready) judge_character(req_data);
         if (rsp_valid && rsp_ready) begin
            if (expected_verdicts.size() == 0) begin
               report_mismatch($sformatf("unexpected result verdict %0d length %0d",
                  rsp_data.verdict, rsp_data.token_length));
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_data.verdict !== want.verdict)
                  report_mismatch($sformatf("verdict %0d, wanted %0d (length %0d)",
                     rsp_data.verdict, want.verdict, want.token_length));
               if (rsp_data.token_length !== want.token_length)
                  report_mismatch($sformatf("token length %0d, wanted %0d",
                     rsp_data.token_length, want.token_length));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic write_csr(input tcv_pkg::csr_index_type idx, input logic [7:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         tcv_pkg::CSR_PROFILE: cfg_profile = tcv_pkg::profile_type'(value[1:0]);
         tcv_pkg::CSR_LEN_LO: cfg_min = value;
         tcv_pkg::CSR_LEN_HI: cfg_max = value;
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic configure(input tcv_pkg::profile_type p, input int lo, input int hi);
      write_csr(tcv_pkg::CSR_PROFILE, 8'(p));
      write_csr(tcv_pkg::CSR_LEN_LO, 8'(lo));
      write_csr(tcv_pkg::CSR_LEN_HI, 8'(hi));
   endtask

   task automatic wait_until_drained();
      while (pending_chars.size() != 0 || req_valid || expected_verdicts.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic push_char(input logic [7:0] c, input logic last);
      tcv_pkg::req_type item;
      item.character = c;
      item.is_last = last;
      pending_chars = {pending_chars, item};
   endtask

   task automatic queue_text(input string s);
      int k;
      for (k = 0; k < s.len(); k++) push_char(s[k], k == s.len() - 1);
   endtask

   function automatic logic [7:0] pick_char(tcv_pkg::profile_type p, char_pick_type want);
      logic [7:0] c;
      tcv_pkg::char_class_type cls;
      int tries;
      c = 8'($urandom_range(0, 255));
      if (p == tcv_pkg::PROFILE_UNDEF) return c;
      for (tries = 0; tries < 4000; tries++) begin
         c = 8'($urandom_range(0, 255));
         cls = classify(p, c);
         case (want)
            PICK_EDGE_OK: if (cls.in_set && !cls.edge_bad) return c;
            PICK_BODY_OK: if (cls.in_set) return c;
            PICK_PLAIN: if (cls.in_set && !cls.sep) return c;
            PICK_SEP: if (cls.sep) return c;
            PICK_EDGE_BAD: if (cls.edge_bad) return c;
            default: if (!cls.in_set) return c;
         endcase
      end
      return c;
   endfunction

   task automatic queue_token(input int len, input token_shape_type shape);
      logic [7:0] text [0:299];
      tcv_pkg::char_class_type cls;
      logic prev_sep;
      logic has_sep;
      int k;
      int pos;
      has_sep = cfg_profile == tcv_pkg::PROFILE_LOWER || cfg_profile == tcv_pkg::PROFILE_HEX;
      prev_sep = 1'b0;
      for (k = 0; k < len; k++) begin
         if (k == 0 || k == len - 1) text[k] = pick_char(cfg_profile, PICK_EDGE_OK);
         else if (prev_sep) text[k] = pick_char(cfg_profile, PICK_PLAIN);
         else if (has_sep && $urandom_range(0, 3) == 0) text[k] = pick_char(cfg_profile, PICK_SEP);
         else text[k] = pick_char(cfg_profile, PICK_BODY_OK);
         cls = classify(cfg_profile, text[k]);
         prev_sep = cls.sep;
      end
      case (shape)
         TOKEN_BAD_FIRST: text[0] = pick_char(cfg_profile, PICK_EDGE_BAD);
         TOKEN_BAD_LAST: text[len - 1] = pick_char(cfg_profile, PICK_EDGE_BAD);
         TOKEN_BAD_CHAR: text[$urandom_range(0, len - 1)] = pick_char(cfg_profile, PICK_OUTSIDE);
         TOKEN_DOUBLE_SEP: begin
            if (len >= 4 && has_sep) begin
               pos = $urandom_range(1, len - 3);
               text[pos] = pick_char(cfg_profile, PICK_SEP);
               text[pos + 1] = pick_char(cfg_profile, PICK_SEP);
            end
         end
         TOKEN_NOISE: for (k = 0; k < len; k++) text[k] = 8'($urandom_range(0, 255));
         default: ;
      endcase
      for (k = 0; k < len; k++) push_char(text[k], k == len - 1);
   endtask

   initial begin
      int phase;
      int phase_chars;
      int len;
      int r;
      int spin;
      int lo;
      token_shape_type shape;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed tokens under the reset configuration
      queue_text("a");
      queue_text("a.-b");
      push_char(8'hFF, 1'b1);
      queue_text("ab_");
      push_char("a", 1'b0);
      push_char(8'h00, 1'b0);
      push_char("b", 1'b1);
      // profile switched between characters of one token
      push_char("z", 1'b0);
      wait_until_drained();
      write_csr(tcv_pkg::CSR_PROFILE, 8'(tcv_pkg::PROFILE_HEX));
      queue_text("0f");
      queue_text("-a");
      wait_until_drained();
      write_csr(tcv_pkg::CSR_PROFILE, 8'(tcv_pkg::PROFILE_PRINT));
      queue_text("~ ~");
      push_char(8'h7F, 1'b1);
      wait_until_drained();
      write_csr(tcv_pkg::CSR_PROFILE, 8'(tcv_pkg::PROFILE_UNDEF));
      queue_text("ab");
      wait_until_drained();
      configure(tcv_pkg::PROFILE_LOWER, 10, 5);
      queue_text("abc");
      wait_until_drained();

      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0: configure(tcv_pkg::PROFILE_LOWER, 1, 255);
            1: begin
               lo = $urandom_range(1, 4);
               configure(tcv_pkg::PROFILE_HEX, lo, lo + $urandom_range(0, 12));
            end
            2: configure(tcv_pkg::PROFILE_PRINT, 1, 255);
            3: begin
               lo = $urandom_range(2, 6);
               configure(tcv_pkg::PROFILE_LOWER, lo, lo);
            end
            4: configure(tcv_pkg::PROFILE_HEX, 255, 255);
            5: configure(tcv_pkg::PROFILE_PRINT, 1, 1);
            6: configure(tcv_pkg::PROFILE_UNDEF, 1, $urandom_range(1, 255));
            default: configure(tcv_pkg::PROFILE_LOWER, $urandom_range(1, 3),
                               $urandom_range(8, 255));
         endcase
         if (phase == 1) hold_requests++;
         if (phase == 7) quiet_tail = 1'b1;
         // one token long enough to saturate the counter
         if (phase == 2) queue_token(tcv_pkg::COUNT_SAT + 2, TOKEN_CLEAN);
         phase_chars = 0;
         while (phase_chars < 20) begin
            r = $urandom_range(0, 99);
            if (r < 65) len = $urandom_range(1, 6);
            else if (r < 95) len = $urandom_range(7, 16);
            else len = $urandom_range(17, 40);
            r = $urandom_range(0, 99);
            if (r < 60) shape = TOKEN_CLEAN;
            else if (r < 70) shape = TOKEN_BAD_FIRST;
            else if (r < 80) shape = TOKEN_BAD_LAST;
            else if (r < 88) shape = TOKEN_BAD_CHAR;
            else if (r < 95) shape = TOKEN_DOUBLE_SEP;
            else shape = TOKEN_NOISE;
            queue_token(len, shape);
            phase_chars += len;
         end
         if (phase < 7) wait_until_drained();
      end

      while (pending_chars.size() != 0 || req_valid) @(posedge clock);
      for (spin = 0; spin < 1000 && expected_verdicts.size() != 0; spin++) @(posedge clock);
      repeat (8) @(posedge clock);
      if (expected_verdicts.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_verdicts.size()));
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
